// ----- rtl/core/texture_gradient_scatter_add_core_assert.svh -----
// Assertion macros for the texture gradient scatter-add core.
// Used by the controller; expects clk and rst_n in scope.
`ifndef TEXTURE_GRADIENT_SCATTER_ADD_CORE_ASSERT_SVH
`define TEXTURE_GRADIENT_SCATTER_ADD_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define TGSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define TGSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGSA_ASSERT_IMP(lbl, ante, cons, msg)
`define TGSA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/tgsa_pkg.sv -----
// Shared types for the texture gradient scatter-add core.
// Command and status bundles between controller and datapath; no dependencies.
package tgsa_pkg;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic calc;
    logic mem_rd;
    logic finish;
  } tgsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic slot_free;
  } tgsa_sts_t;

endpackage

// ----- rtl/core/tgsa_ctrl.sv -----
// Sequencing state machine for the texture gradient scatter-add core.
// Depends on tgsa_pkg and the assertion macro header.
`include "texture_gradient_scatter_add_core_assert.svh"

module tgsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tgsa_pkg::tgsa_sts_t sts,
  output tgsa_pkg::tgsa_cmd_t cmd
);
  import tgsa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ADDR  = 5'b00100,
    S_RDMEM = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_RDMEM;
      S_RDMEM: state_nxt = S_FIN;
      S_FIN:   if (sts.slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands
  assign in_ready     = (state_r == S_IDLE);
  assign cmd.clear_wr = (state_r == S_CLEAR);
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.calc     = (state_r == S_ADDR);
  assign cmd.mem_rd   = (state_r == S_RDMEM);
  assign cmd.finish   = (state_r == S_FIN) && sts.slot_free;

  `TGSA_ASSERT_NXT(a_capture_to_addr, cmd.capture, state_r == S_ADDR, "item capture did not advance")
  `TGSA_ASSERT_NXT(a_read_to_fin, state_r == S_RDMEM, state_r == S_FIN, "read did not advance")
  `TGSA_ASSERT_NXT(a_fin_stall, (state_r == S_FIN) && !sts.slot_free, state_r == S_FIN, "left finish while output full")
  `TGSA_ASSERT_NXT(a_clear_hold, (state_r == S_CLEAR) && !sts.clear_last, state_r == S_CLEAR, "clear pass cut short")
  `TGSA_ASSERT_IMP(a_no_accept_clear, cmd.clear_wr, !in_ready, "item accepted during clear")

endmodule

// ----- rtl/core/tgsa_datapath.sv -----
// Datapath of the texture gradient scatter-add core: config registers, address
// decode, texel store, saturating adders and output register. Depends on tgsa_pkg.
module tgsa_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_LEVELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tgsa_pkg::tgsa_cmd_t cmd,
  output tgsa_pkg::tgsa_sts_t sts,
  input  logic                in_cmd,
  input  logic signed [6:0]   in_x_coord,
  input  logic [4:0]          in_y_coord,
  input  logic signed [2:0]   in_level_index,
  input  logic [2:0]          in_corner,
  input  logic signed [31:0]  in_grad_red,
  input  logic signed [31:0]  in_grad_green,
  input  logic signed [31:0]  in_grad_blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_red_value,
  output logic signed [31:0]  out_green_value,
  output logic signed [31:0]  out_blue_value,
  output logic [1:0]          out_status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata
);
  import tgsa_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_LEVELS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RST_WIDTH   = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int RST_HEIGHT  = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;
  localparam int TW_W        = 7;
  localparam int TH_W        = 6;
  localparam int LC_W        = 3;
  localparam int LVTH_W      = 9;
  localparam int LIN_W       = 18;
  localparam int TEXEL_W     = 96;

  localparam logic [1:0] CFG_TEX_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_TEX_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SKIP  = 2'd2;

  localparam logic       CMD_ACC    = 1'b0;
  localparam logic [2:0] LEVEL_NONE = 3'b111;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  // Configuration registers
  logic [TW_W-1:0] tex_width_r;
  logic [TH_W-1:0] tex_height_r;
  logic [LC_W-1:0] level_count_r;
  logic [TW_W-1:0] wr_width;
  logic [TH_W-1:0] wr_height;
  logic [LC_W-1:0] wr_levels;

  // Clamp written values, taken from the low 7, 6 or 3 bits: zero reads as one, above the maximum reads as the maximum
  always_comb begin
    wr_width = cfg_wdata;
    if (wr_width == '0) wr_width = TW_W'(1);
    else if (int'(wr_width) > MAX_WIDTH) wr_width = TW_W'(MAX_WIDTH);
    wr_height = cfg_wdata[TH_W-1:0];
    if (wr_height == '0) wr_height = TH_W'(1);
    else if (int'(wr_height) > MAX_HEIGHT) wr_height = TH_W'(MAX_HEIGHT);
    wr_levels = cfg_wdata[LC_W-1:0];
    if (wr_levels == '0) wr_levels = LC_W'(1);
    else if (int'(wr_levels) > MAX_LEVELS) wr_levels = LC_W'(MAX_LEVELS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r   <= TW_W'(RST_WIDTH);
      tex_height_r  <= TH_W'(RST_HEIGHT);
      level_count_r <= LC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:   tex_width_r   <= wr_width;
        CFG_TEX_HEIGHT:  tex_height_r  <= wr_height;
        CFG_LEVEL_COUNT: level_count_r <= wr_levels;
        default: ;
      endcase
    end
  end

  // Decode the incoming item
  logic            is_acc;
  logic            li_neg;
  logic [TW_W-1:0] x0, xp1, xs;
  logic [TH_W-1:0] y0, yp1, ys;
  logic [LC_W-1:0] lv_base, lvp1, lv;
  logic [1:0]      dec_status;

  always_comb begin
    is_acc  = (in_cmd == CMD_ACC);
    li_neg  = in_level_index[2];
    x0      = {1'b0, in_x_coord[5:0]};
    y0      = {1'b0, in_y_coord};
    lv_base = li_neg ? '0 : {1'b0, in_level_index[1:0]};
    xp1     = x0 + TW_W'(1);
    yp1     = y0 + TH_W'(1);
    lvp1    = lv_base + LC_W'(1);
    xs      = x0;
    ys      = y0;
    lv      = lv_base;
    dec_status = ST_DONE;
    if (is_acc && in_corner[0]) xs = (xp1 == tex_width_r) ? '0 : xp1;
    if (is_acc && in_corner[1]) ys = (yp1 == tex_height_r) ? '0 : yp1;
    if (is_acc && in_corner[2]) lv = lvp1;
    priority if (in_x_coord[6]) begin
      // constant texture: entry 0 only
      xs = '0;
      ys = '0;
      lv = '0;
      if (is_acc && in_corner != 3'd0) dec_status = ST_SKIP;
    end else if (x0 >= tex_width_r || y0 >= tex_height_r ||
                 (li_neg && in_level_index != LEVEL_NONE) ||
                 (!li_neg && lv_base >= level_count_r)) begin
      dec_status = ST_RANGE;
    end else if (is_acc && in_corner[2] && (li_neg || lvp1 >= level_count_r)) begin
      dec_status = ST_SKIP;
    end else begin
      dec_status = ST_DONE;
    end
  end

  // Item registers
  logic              is_acc_r;
  logic [TW_W-1:0]   xs_r;
  logic [TH_W-1:0]   ys_r;
  logic [LVTH_W-1:0] lvth_r;
  logic [1:0]        status_r;
  logic [31:0]       grad_red_r, grad_green_r, grad_blue_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LIN_W-1:0]  lin_addr;

  assign lin_addr = (LIN_W'(lvth_r) + LIN_W'(ys_r)) * LIN_W'(tex_width_r) + LIN_W'(xs_r);

  // Capture decode results, then form the linear address
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_acc_r     <= is_acc;
      xs_r         <= xs;
      ys_r         <= ys;
      lvth_r       <= LVTH_W'(lv) * LVTH_W'(tex_height_r);
      status_r     <= dec_status;
      grad_red_r   <= in_grad_red;
      grad_green_r <= in_grad_green;
      grad_blue_r  <= in_grad_blue;
    end else if (cmd.calc) begin
      addr_r <= ADDR_W'(lin_addr);
      if (status_r == ST_DONE && int'(lin_addr) >= STORE_DEPTH) status_r <= ST_RANGE;
    end
  end

  // Clear pointer
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1));

  // Texel store: {red, green, blue}
  logic [TEXEL_W-1:0] mem [STORE_DEPTH];
  logic [TEXEL_W-1:0] rd_data_r;
  logic [31:0]        sum_red, sum_green, sum_blue;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [TEXEL_W-1:0] mem_wdata;

  assign sum_red   = sat_add(rd_data_r[95:64], grad_red_r);
  assign sum_green = sat_add(rd_data_r[63:32], grad_green_r);
  assign sum_blue  = sat_add(rd_data_r[31:0], grad_blue_r);

  assign mem_we    = cmd.clear_wr || (cmd.finish && is_acc_r && status_r == ST_DONE);
  assign mem_waddr = cmd.clear_wr ? clr_cnt_r : addr_r;
  assign mem_wdata = cmd.clear_wr ? '0 : {sum_red, sum_green, sum_blue};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rd_data_r <= mem[addr_r];
  end

  // Output register
  logic        out_valid_r;
  logic [31:0] out_red_r, out_green_r, out_blue_r;
  logic [1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_r;
      priority if (status_r != ST_DONE) begin
        out_red_r   <= '0;
        out_green_r <= '0;
        out_blue_r  <= '0;
      end else if (is_acc_r) begin
        out_red_r   <= sum_red;
        out_green_r <= sum_green;
        out_blue_r  <= sum_blue;
      end else begin
        out_red_r   <= rd_data_r[95:64];
        out_green_r <= rd_data_r[63:32];
        out_blue_r  <= rd_data_r[31:0];
      end
    end
  end

  assign sts.slot_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_red_value   = out_red_r;
  assign out_green_value = out_green_r;
  assign out_blue_value  = out_blue_r;
  assign out_status      = out_status_r;

endmodule

// ----- rtl/core/texture_gradient_scatter_add_core.sv -----
// Texture gradient scatter-add core, top level.
// Steps per item: capture, address multiply, registered store read, write-back.
// Write-back waits for a free output slot; the next item is taken after it.
// Reset: synchronous, active low; then a clearing pass zeroes the store, one
// texel a cycle, all MAX_WIDTH*MAX_HEIGHT*MAX_LEVELS texels (8192 by default),
// during which no item is accepted. Config writes are taken at any time.
module texture_gradient_scatter_add_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_LEVELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic signed [6:0]  in_x_coord,
  input  logic [4:0]         in_y_coord,
  input  logic signed [2:0]  in_level_index,
  input  logic [2:0]         in_corner,
  input  logic signed [31:0] in_grad_red,
  input  logic signed [31:0] in_grad_green,
  input  logic signed [31:0] in_grad_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_red_value,
  output logic signed [31:0] out_green_value,
  output logic signed [31:0] out_blue_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_wdata
);
  import tgsa_pkg::*;

  tgsa_cmd_t cmd;
  tgsa_sts_t sts;

  // Sequencer
  tgsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Address, store and output datapath
  tgsa_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_level_index  (in_level_index),
    .in_corner       (in_corner),
    .in_grad_red     (in_grad_red),
    .in_grad_green   (in_grad_green),
    .in_grad_blue    (in_grad_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_value   (out_red_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule

// ----- bench/tb_texture_gradient_scatter_add_core.sv -----
// Testbench for texture_gradient_scatter_add_core: directed and random splat/read items.
// Keeps its own texel store and geometry to predict every result and compare it.
// Depends only on the core RTL; no files, no arguments.
`timescale 1ns / 1ps

module tb_texture_gradient_scatter_add_core;

  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 32;
  localparam int MAX_LEVELS      = 4;
  localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT * MAX_LEVELS;
  localparam int LATENCY_PAD     = 8;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 94;

  typedef enum logic {CMD_ACCUM = 1'b0, CMD_READ = 1'b1} splat_cmd_e;
  typedef enum logic [1:0] {ST_DONE = 2'd0, ST_RANGE = 2'd1, ST_SKIP = 2'd2} texel_status_e;
  typedef enum logic [1:0] {REG_WIDTH = 2'd0, REG_HEIGHT = 2'd1, REG_LEVELS = 2'd2} geom_reg_e;

  typedef struct {
    splat_cmd_e         cmd;
    logic signed [6:0]  x_coord;
    logic [4:0]         y_coord;
    logic signed [2:0]  level_index;
    logic [2:0]         corner;
    logic signed [31:0] grad_red;
    logic signed [31:0] grad_green;
    logic signed [31:0] grad_blue;
  } splat_item_t;

  typedef struct {
    logic signed [31:0] red;
    logic signed [31:0] green;
    logic signed [31:0] blue;
    texel_status_e      status;
  } texel_result_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // Block inputs, all known from time zero
  logic               in_valid = 1'b0;
  logic               in_cmd = 1'b0;
  logic signed [6:0]  in_x_coord = '0;
  logic [4:0]         in_y_coord = '0;
  logic signed [2:0]  in_level_index = '0;
  logic [2:0]         in_corner = '0;
  logic signed [31:0] in_grad_red = '0;
  logic signed [31:0] in_grad_green = '0;
  logic signed [31:0] in_grad_blue = '0;
  logic               out_ready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [6:0]         cfg_wdata = '0;

  // Block outputs
  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] out_red_value;
  logic signed [31:0] out_green_value;
  logic signed [31:0] out_blue_value;
  logic [1:0]         out_status;

  texture_gradient_scatter_add_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_level_index  (in_level_index),
    .in_corner       (in_corner),
    .in_grad_red     (in_grad_red),
    .in_grad_green   (in_grad_green),
    .in_grad_blue    (in_grad_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_value   (out_red_value),
    .out_green_value (out_green_value),
    .out_blue_value  (out_blue_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Shadow texel store and geometry
  logic signed [31:0] red_mem   [STORE_DEPTH];
  logic signed [31:0] green_mem [STORE_DEPTH];
  logic signed [31:0] blue_mem  [STORE_DEPTH];
  int geom_width  = MAX_WIDTH;
  int geom_height = MAX_HEIGHT;
  int geom_levels = 1;

  texel_result_t texel_expect_q[$];
  bit steady_flow = 1'b0;
  int err_count = 0;
  int items_sent = 0;
  int reads_sent = 0;
  int results_checked = 0;
  int clamp_count = 0;
  int geom_settings = 1;
  int status_seen [3] = '{0, 0, 0};

  // Clamp a register value to 1..hi
  function automatic int fit_reg(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Add with clamping to the signed 32-bit range
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) begin
      s = 64'sd2147483647;
      clamp_count++;
    end else if (s < -64'sd2147483648) begin
      s = -64'sd2147483648;
      clamp_count++;
    end
    return s[31:0];
  endfunction

  // Apply one item to the shadow store and return the texel it reports
  function automatic texel_result_t apply_splat(input splat_item_t it);
    texel_result_t r;
    int xv, li, xs, ys, lv, addr;
    bit accum;
    r.red = '0;
    r.green = '0;
    r.blue = '0;
    r.status = ST_DONE;
    accum = (it.cmd == CMD_ACCUM);
    xv = it.x_coord;
    li = it.level_index;
    if (xv < 0) begin
      // constant texture: only the base corner lands, always on entry 0
      if (accum && it.corner != 3'd0) r.status = ST_SKIP;
      addr = 0;
    end else if (xv >= geom_width || int'(it.y_coord) >= geom_height || li < -1 ||
                 (li >= 0 && li >= geom_levels)) begin
      r.status = ST_RANGE;
    end else begin
      xs = xv;
      ys = int'(it.y_coord);
      lv = (li < 0) ? 0 : li;
      if (accum) begin
        if (it.corner[0]) xs = (xs + 1 == geom_width) ? 0 : xs + 1;
        if (it.corner[1]) ys = (ys + 1 == geom_height) ? 0 : ys + 1;
        if (it.corner[2]) begin
          if (li < 0 || lv + 1 >= geom_levels) r.status = ST_SKIP;
          lv = lv + 1;
        end
      end
      addr = (lv * geom_height + ys) * geom_width + xs;
      if (r.status == ST_DONE && addr >= STORE_DEPTH) r.status = ST_RANGE;
    end
    if (r.status == ST_DONE) begin
      if (accum) begin
        red_mem[addr]   = sat_add(red_mem[addr], it.grad_red);
        green_mem[addr] = sat_add(green_mem[addr], it.grad_green);
        blue_mem[addr]  = sat_add(blue_mem[addr], it.grad_blue);
      end
      r.red = red_mem[addr];
      r.green = green_mem[addr];
      r.blue = blue_mem[addr];
    end
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic splat_item_t make_splat(input splat_cmd_e cmd, input int x, input int y,
                                             input int li, input int corner,
                                             input logic [31:0] r, input logic [31:0] g,
                                             input logic [31:0] b);
    splat_item_t it;
    it.cmd = cmd;
    it.x_coord = 7'(x);
    it.y_coord = 5'(y);
    it.level_index = 3'(li);
    it.corner = 3'(corner);
    it.grad_red = r;
    it.grad_green = g;
    it.grad_blue = b;
    return it;
  endfunction

  // Gradient values weighted toward the clamp limits and small fractions
  function automatic logic signed [31:0] rand_grad();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2:       return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range splats, some constant texture, the rest raw noise
  function automatic splat_item_t rand_splat();
    splat_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.cmd = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ACCUM;
    it.corner = 3'($urandom_range(0, 7));
    it.grad_red = rand_grad();
    it.grad_green = rand_grad();
    it.grad_blue = rand_grad();
    it.y_coord = 5'($urandom);
    it.level_index = 3'($urandom);
    if (pick < 80) begin
      it.x_coord = 7'($urandom_range(0, geom_width - 1));
      it.y_coord = 5'($urandom_range(0, geom_height - 1));
      it.level_index = 3'(int'($urandom_range(0, geom_levels)) - 1);
    end else if (pick < 88) begin
      it.x_coord = 7'(-int'($urandom_range(1, 64)));
      if ($urandom_range(0, 1) == 0) it.corner = 3'd0;
    end else begin
      it.x_coord = 7'($urandom);
    end
    return it;
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_splat(input splat_item_t it);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= it.cmd;
    in_x_coord     <= it.x_coord;
    in_y_coord     <= it.y_coord;
    in_level_index <= it.level_index;
    in_corner      <= it.corner;
    in_grad_red    <= it.grad_red;
    in_grad_green  <= it.grad_green;
    in_grad_blue   <= it.grad_blue;
    do @(posedge clk); while (in_ready !== 1'b1);
    texel_expect_q.push_back(apply_splat(it));
    items_sent++;
    if (it.cmd == CMD_READ) reads_sent++;
  endtask

  // Drop valid and let every expected texel come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (texel_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Write all three geometry registers on consecutive cycles
  task automatic set_geometry(input logic [6:0] w, input logic [6:0] h, input logic [6:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_LEVELS;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    geom_width  = fit_reg(w, MAX_WIDTH);
    geom_height = fit_reg(h[5:0], MAX_HEIGHT);
    geom_levels = fit_reg(l[2:0], MAX_LEVELS);
    geom_settings++;
  endtask

  // Reset geometry: cleared store, wrap at the full row and column, single level
  task automatic test_reset_defaults();
    send_splat(make_splat(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 63, 31, 0, 3, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000));
    send_splat(make_splat(CMD_ACCUM, 10, 10, 0, 4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_splat(make_splat(CMD_ACCUM, 10, 10, 1, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    wait_quiet();
  endtask

  // Every corner from the last texel of a small level, wrapping x and y and stepping to the next level
  task automatic test_corner_wrap();
    set_geometry(7'd5, 7'd3, 7'd3);
    for (int c = 0; c < 8; c++)
      send_splat(make_splat(CMD_ACCUM, 4, 2, 1, c, (c + 1) << 16, -((c + 1) << 12), c));
    send_splat(make_splat(CMD_READ, 0, 0, 2, 0, 0, 0, 0));
    send_splat(make_splat(CMD_READ, 4, 2, 1, 7, 0, 0, 0));
    wait_quiet();
  endtask

  // Constant texture, skipped corners, out-of-range coordinates and clamping
  task automatic test_special_cases();
    send_splat(make_splat(CMD_ACCUM, -1, 31, -4, 0, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000));
    send_splat(make_splat(CMD_ACCUM, -64, 0, 0, 5, 32'h0001_0000, 0, 0));
    send_splat(make_splat(CMD_READ, -5, 7, 3, 6, 0, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 1, 1, -1, 4, 32'h0001_0000, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 1, 1, 2, 4, 32'h0001_0000, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 1, 1, -2, 0, 32'h0001_0000, 0, 0));
    send_splat(make_splat(CMD_READ, 1, 1, -4, 0, 0, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 5, 0, 0, 0, 32'h0001_0000, 0, 0));
    send_splat(make_splat(CMD_ACCUM, 0, 3, 0, 0, 32'h0001_0000, 0, 0));
    // push one texel past both clamp limits
    repeat (2)
      send_splat(make_splat(CMD_ACCUM, 1, 1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
    wait_quiet();
  endtask

  // Random items over a spread of geometries, register extremes included
  task automatic test_random_geometry();
    logic [6:0] w, h, l;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin w = 7'd64; h = 7'd32; l = 7'd4; end
        1: begin w = 7'd1; h = 7'd1; l = 7'd1; end
        2: begin w = 7'd0; h = 7'd0; l = 7'd0; end
        3: begin w = 7'h7F; h = 7'h7F; l = 7'h7F; end
        4: begin w = 7'd2; h = 7'd64; l = 7'd8; end
        5: begin w = 7'd3; h = 7'd2; l = 7'd4; end
        default: begin
          w = 7'($urandom_range(1, 64));
          h = 7'($urandom_range(1, 32));
          l = 7'($urandom_range(1, 4));
        end
      endcase
      set_geometry(w, h, l);
      // one phase runs back to back on both sides
      steady_flow = (ph == 5);
      repeat (ITEMS_PER_PHASE) send_splat(rand_splat());
      wait_quiet();
    end
    steady_flow = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Take results with random stalls and compare against the oldest expectation
  initial begin : result_checker
    int stall;
    texel_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (texel_expect_q.size() == 0) begin
        $error("result with no item outstanding: status %0d", out_status);
        err_count++;
      end else begin
        want = texel_expect_q.pop_front();
        check_field("red_value", want.red, out_red_value);
        check_field("green_value", want.green, out_green_value);
        check_field("blue_value", want.blue, out_blue_value);
        check_field("status", {30'd0, want.status}, {30'd0, out_status});
        results_checked++;
      end
    end
  end

  // Main sequence
  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      red_mem[i] = '0;
      green_mem[i] = '0;
      blue_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_corner_wrap();
    test_special_cases();
    test_random_geometry();
    $display("Checked %0d results from %0d items (%0d reads) over %0d geometry settings.",
             results_checked, items_sent, reads_sent, geom_settings);
    $display("Status mix: %0d done, %0d out of range, %0d skipped; %0d channel adds clamped.",
             status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_SKIP], clamp_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", texel_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tgsa_pkg.sv
rtl/core/tgsa_ctrl.sv
rtl/core/tgsa_datapath.sv
rtl/core/texture_gradient_scatter_add_core.sv
bench/tb_texture_gradient_scatter_add_core.sv
